// ===== rtl/dltq_pkg.sv =====
// package: shared types and constants of the delta list timer queue
package dltq_pkg;

  localparam int TableSlots = 16;
  localparam int Capacity   = TableSlots - 1;
  localparam int IdxW       = $clog2(TableSlots);

  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_SCHEDULE = 2'd1,
    ACT_CANCEL   = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_FIRED     = 3'd0,
    KIND_SCHEDULED = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_CANCELLED = 3'd3,
    KIND_NOT_FOUND = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_SCAN,
    ST_TICK_FIRE,
    ST_TICK_SHIFT,
    ST_SCHED_SCAN,
    ST_SCHED_SHIFT,
    ST_SCHED_PUT,
    ST_CAN_SCAN,
    ST_CAN_SHIFT,
    ST_REPORT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic  load;       // capture the input item
    logic  clr_ptr;    // pointer to zero
    logic  inc_ptr;    // pointer up by one
    logic  set_ptr_n;  // pointer to occupied count
    logic  dec_ptr;    // pointer down by one
    logic  mark_ins;   // remember pointer as the insert point
    logic  tick_dec;   // decrement delta at pointer
    logic  sched_sub;  // subtract delta at pointer from working delay
    logic  sched_fix;  // take working delay off delta at pointer
    logic  move_up;    // entry ptr-1 to ptr
    logic  put_new;    // write new entry at pointer
    logic  fold;       // fold delta at pointer into pointer+1
    logic  move_down;  // entry ptr+1 to ptr
    logic  drop_fired; // shift table down by fire count, one entry a cycle
    logic  count_inc;
    logic  count_dec;
    logic  count_set;  // occupied count minus fire count
    logic  inc_fire;
    logic  emit;
    kind_t emit_kind;
    logic  emit_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    action_t act;
    logic    empty;
    logic    full;
    logic    ptr_end;      // pointer reached occupied count
    logic    ptr_last;     // pointer is last live entry
    logic    delta_zero;   // delta at pointer is zero
    logic    next_zero;    // delta at pointer+1 is zero
    logic    delta_le;     // delta at pointer <= working delay
    logic    match;        // handler at pointer matches
    logic    fire_end;     // pointer+fire reached occupied count
    logic    ptr_is_zero;
    logic    ptr_at_ins;   // pointer is at the insert point
  } stat_t;

endpackage

// ===== rtl/dltq_datapath.sv =====
// datapath: entry table, pointer, working registers and result registers
module dltq_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           action,
  input  logic [7:0]           handler_id,
  input  logic [31:0]          argument,
  input  logic [15:0]          delay,
  input  logic [15:0]          repeat_count,
  input  dltq_pkg::cmd_t       cmd,
  output dltq_pkg::stat_t      stat,
  output logic                 strobe,
  output logic [2:0]           kind,
  output logic [7:0]           fired_handler,
  output logic [31:0]          fired_argument,
  output logic [15:0]          repeats_left,
  output logic                 last
);

  localparam int Cap = dltq_pkg::Capacity;
  localparam int W   = dltq_pkg::IdxW;

  // entry table, register per slot
  logic [7:0]  slot_handler  [Cap];
  logic [15:0] slot_delta    [Cap];
  logic [31:0] slot_argument [Cap];
  logic [15:0] slot_repeats  [Cap];

  logic [W-1:0] occupied_count;
  logic [W-1:0] ptr;
  logic [W-1:0] ins;
  logic [W-1:0] fire;
  logic [1:0]   act;
  logic [7:0]   h;
  logic [31:0]  arg;
  logic [15:0]  t;
  logic [15:0]  rep;

  logic [W-1:0] ptr_p1, ptr_m1, src;
  logic [W:0]   fold_sum_idx;
  logic [16:0]  fold_sum;
  logic [15:0]  cur_delta;
  logic [15:0]  nxt_delta;
  logic         src_ok;

  assign ptr_p1    = ptr + W'(1);
  assign ptr_m1    = ptr - W'(1);
  assign src       = ptr + fire;
  assign cur_delta = (ptr < W'(Cap)) ? slot_delta[ptr[W-1:0]] : '0;
  assign src_ok    = src < W'(Cap);
  assign nxt_delta = (ptr_p1 < W'(Cap)) ? slot_delta[ptr_p1] : '0;
  assign fold_sum  = {1'b0, nxt_delta} + {1'b0, cur_delta};
  assign fold_sum_idx = {1'b0, ptr} + {1'b0, fire};

  // status to the controller
  always_comb begin
    stat.act         = dltq_pkg::action_t'(act);
    stat.empty       = occupied_count == '0;
    stat.full        = occupied_count >= W'(Cap);
    stat.ptr_end     = ptr >= occupied_count;
    stat.ptr_last    = ptr_p1 >= occupied_count;
    stat.delta_zero  = cur_delta == '0;
    stat.next_zero   = nxt_delta == '0;
    stat.delta_le    = cur_delta <= t;
    stat.match       = (ptr < W'(Cap)) ? (slot_handler[ptr] == h) : 1'b0;
    stat.fire_end    = fold_sum_idx >= {1'b0, occupied_count};
    stat.ptr_is_zero = ptr == '0;
    stat.ptr_at_ins  = ptr == ins;
  end

  // input capture, pointer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied_count <= '0;
      ptr            <= '0;
      fire           <= '0;
    end else begin
      if (cmd.load) begin
        act  <= action;
        h    <= handler_id;
        arg  <= argument;
        t    <= delay;
        rep  <= repeat_count;
        fire <= '0;
      end
      if (cmd.clr_ptr)   ptr <= '0;
      if (cmd.inc_ptr)   ptr <= ptr_p1;
      if (cmd.dec_ptr)   ptr <= ptr_m1;
      if (cmd.set_ptr_n) ptr <= occupied_count;
      if (cmd.mark_ins)  ins <= ptr;
      if (cmd.inc_fire)  fire <= fire + W'(1);
      if (cmd.sched_sub) t <= t - cur_delta;
      if (cmd.count_inc) occupied_count <= occupied_count + W'(1);
      if (cmd.count_dec) occupied_count <= occupied_count - W'(1);
      if (cmd.count_set) occupied_count <= occupied_count - fire;
    end
  end

  // table updates, one entry per cycle
  always_ff @(posedge clk) begin
    if (cmd.tick_dec && ptr < W'(Cap))
      slot_delta[ptr] <= cur_delta - 16'd1;
    if (cmd.sched_fix && ptr < W'(Cap))
      slot_delta[ptr] <= cur_delta - t;
    if (cmd.move_up && ptr < W'(Cap) && ptr != '0) begin
      slot_handler[ptr]  <= slot_handler[ptr_m1];
      slot_delta[ptr]    <= slot_delta[ptr_m1];
      slot_argument[ptr] <= slot_argument[ptr_m1];
      slot_repeats[ptr]  <= slot_repeats[ptr_m1];
    end
    if (cmd.put_new && ptr < W'(Cap)) begin
      slot_handler[ptr]  <= h;
      slot_delta[ptr]    <= t;
      slot_argument[ptr] <= arg;
      slot_repeats[ptr]  <= rep;
    end
    if (cmd.fold && ptr_p1 < W'(Cap))
      slot_delta[ptr_p1] <= fold_sum[16] ? 16'hFFFF : fold_sum[15:0];
    if (cmd.move_down && ptr < W'(Cap) && ptr_p1 < W'(Cap)) begin
      slot_handler[ptr]  <= slot_handler[ptr_p1];
      slot_delta[ptr]    <= slot_delta[ptr_p1];
      slot_argument[ptr] <= slot_argument[ptr_p1];
      slot_repeats[ptr]  <= slot_repeats[ptr_p1];
    end
    if (cmd.drop_fired && ptr < W'(Cap) && src_ok) begin
      slot_handler[ptr]  <= slot_handler[src];
      slot_delta[ptr]    <= slot_delta[src];
      slot_argument[ptr] <= slot_argument[src];
      slot_repeats[ptr]  <= slot_repeats[src];
    end
  end

  // result register, one result per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
    if (cmd.emit) begin
      kind <= cmd.emit_kind;
      last <= cmd.emit_last;
      case (cmd.emit_kind)
        dltq_pkg::KIND_FIRED: begin
          fired_handler  <= slot_handler[ptr];
          fired_argument <= slot_argument[ptr];
          repeats_left   <= (slot_repeats[ptr] == '0) ? '0 : slot_repeats[ptr] - 16'd1;
        end
        dltq_pkg::KIND_CANCELLED: begin
          fired_handler  <= h;
          fired_argument <= slot_argument[ptr];
          repeats_left   <= slot_repeats[ptr];
        end
        dltq_pkg::KIND_NOT_FOUND: begin
          fired_handler  <= h;
          fired_argument <= '0;
          repeats_left   <= '0;
        end
        default: begin
          fired_handler  <= h;
          fired_argument <= arg;
          repeats_left   <= rep;
        end
      endcase
    end
  end

  // occupancy never exceeds capacity
  a_cap: assert property (@(posedge clk) disable iff (rst)
    occupied_count <= W'(Cap)) else $error("occupancy above capacity");
  // a count increment only on an insert
  a_inc: assert property (@(posedge clk) disable iff (rst)
    cmd.count_inc |-> cmd.put_new) else $error("count up without insert");
  // result strobe follows an emit command
  a_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(cmd.emit)) else $error("strobe without emit");

endmodule

// ===== rtl/dltq_ctrl.sv =====
// controller: state machine sequencing tick, schedule and cancel walks
module dltq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dltq_pkg::stat_t     stat,
  output dltq_pkg::cmd_t      cmd
);

  dltq_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= dltq_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit_kind = dltq_pkg::KIND_FIRED;
    busy       = state != dltq_pkg::ST_IDLE;
    case (state)
      dltq_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.clr_ptr = 1'b1;
          state_next  = dltq_pkg::ST_REPORT;
        end
      end
      // dispatch on the captured action
      dltq_pkg::ST_REPORT: begin
        case (stat.act)
          dltq_pkg::ACT_TICK:
            state_next = stat.empty ? dltq_pkg::ST_IDLE : dltq_pkg::ST_TICK_SCAN;
          dltq_pkg::ACT_SCHEDULE: begin
            if (stat.full) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = dltq_pkg::KIND_FULL;
              cmd.emit_last = 1'b1;
              state_next    = dltq_pkg::ST_IDLE;
            end else begin
              state_next = dltq_pkg::ST_SCHED_SCAN;
            end
          end
          dltq_pkg::ACT_CANCEL: state_next = dltq_pkg::ST_CAN_SCAN;
          default: state_next = dltq_pkg::ST_IDLE;
        endcase
      end
      // find first nonzero delta and decrement it
      dltq_pkg::ST_TICK_SCAN: begin
        if (stat.ptr_end) begin
          cmd.clr_ptr = 1'b1;
          state_next  = dltq_pkg::ST_TICK_FIRE;
        end else if (!stat.delta_zero) begin
          cmd.tick_dec = 1'b1;
          cmd.clr_ptr  = 1'b1;
          state_next   = dltq_pkg::ST_TICK_FIRE;
        end else begin
          cmd.inc_ptr = 1'b1;
        end
      end
      // emit leading zero-delta entries, last where the run of zeros ends
      dltq_pkg::ST_TICK_FIRE: begin
        if (!stat.ptr_end && stat.delta_zero) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = dltq_pkg::KIND_FIRED;
          cmd.emit_last = stat.ptr_last | !stat.next_zero;
          cmd.inc_ptr   = 1'b1;
          cmd.inc_fire  = 1'b1;
        end else if (stat.ptr_is_zero) begin
          state_next = dltq_pkg::ST_IDLE;
        end else begin
          cmd.clr_ptr = 1'b1;
          state_next  = dltq_pkg::ST_TICK_SHIFT;
        end
      end
      // move survivors down by the fire count
      dltq_pkg::ST_TICK_SHIFT: begin
        if (stat.fire_end) begin
          cmd.count_set = 1'b1;
          state_next    = dltq_pkg::ST_IDLE;
        end else begin
          cmd.drop_fired = 1'b1;
          cmd.inc_ptr    = 1'b1;
        end
      end
      // walk subtracting deltas
      dltq_pkg::ST_SCHED_SCAN: begin
        if (!stat.ptr_end && stat.delta_le) begin
          cmd.sched_sub = 1'b1;
          cmd.inc_ptr   = 1'b1;
        end else begin
          cmd.sched_fix = !stat.ptr_end;
          cmd.mark_ins  = 1'b1;
          cmd.set_ptr_n = 1'b1;
          state_next    = dltq_pkg::ST_SCHED_SHIFT;
        end
      end
      // open a gap from the top down to the insert point
      dltq_pkg::ST_SCHED_SHIFT: begin
        if (stat.ptr_at_ins) begin
          state_next = dltq_pkg::ST_SCHED_PUT;
        end else begin
          cmd.move_up = 1'b1;
          cmd.dec_ptr = 1'b1;
        end
      end
      // write the new entry and report it
      dltq_pkg::ST_SCHED_PUT: begin
        cmd.put_new   = 1'b1;
        cmd.count_inc = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_kind = dltq_pkg::KIND_SCHEDULED;
        cmd.emit_last = 1'b1;
        state_next    = dltq_pkg::ST_IDLE;
      end
      // search for a matching handler
      dltq_pkg::ST_CAN_SCAN: begin
        if (stat.ptr_end) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = dltq_pkg::KIND_NOT_FOUND;
          cmd.emit_last = 1'b1;
          state_next    = dltq_pkg::ST_IDLE;
        end else if (stat.match) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = dltq_pkg::KIND_CANCELLED;
          cmd.emit_last = 1'b1;
          cmd.fold      = !stat.ptr_last;
          state_next    = dltq_pkg::ST_CAN_SHIFT;
        end else begin
          cmd.inc_ptr = 1'b1;
        end
      end
      // close the gap
      dltq_pkg::ST_CAN_SHIFT: begin
        if (stat.ptr_last) begin
          cmd.count_dec = 1'b1;
          state_next    = dltq_pkg::ST_IDLE;
        end else begin
          cmd.move_down = 1'b1;
          cmd.inc_ptr   = 1'b1;
        end
      end
      default: state_next = dltq_pkg::ST_IDLE;
    endcase
  end

  // no new item taken while busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != dltq_pkg::ST_IDLE) |-> !cmd.load) else $error("load while busy");
  // insert and removal never in the same cycle
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.count_inc && cmd.count_dec)) else $error("count conflict");
  // fired results come only from the fire state
  a_fire: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.emit_kind == dltq_pkg::KIND_FIRED) |->
      (state == dltq_pkg::ST_TICK_FIRE)) else $error("stray fired result");

endmodule

// ===== rtl/delta_list_timer_queue.sv =====
// top level: delta list timer queue, controller plus datapath
// An item is taken when start is high and busy is low; busy then stays high
// until every result of the item has left the output register. Results appear
// one per cycle while strobe is high and cannot be stalled by the receiver.
// One item is a walk over the table entries followed by passes that emit or
// shift entries, one entry per cycle. A tick on an empty table or an unused
// action is the shortest case and a tick that fires a full table is the
// longest. Results of a tick come back-to-back, one a cycle, with last
// marking the final one; a schedule or cancel gives one result.
module delta_list_timer_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [7:0]  handler_id,
  input  logic [31:0] argument,
  input  logic [15:0] delay,
  input  logic [15:0] repeat_count,
  output logic        strobe,
  output logic [2:0]  kind,
  output logic [7:0]  fired_handler,
  output logic [31:0] fired_argument,
  output logic [15:0] repeats_left,
  output logic        last
);

  dltq_pkg::cmd_t  cmd;
  dltq_pkg::stat_t stat;
  logic            ctrl_busy;
  logic            ctrl_start;

  // no item taken while the final result is still shown
  assign ctrl_start = start & ~strobe;

  dltq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(ctrl_start),
    .busy (ctrl_busy),
    .stat (stat),
    .cmd  (cmd)
  );

  // busy covers the final result still in the output register
  assign busy = ctrl_busy | strobe;

  dltq_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .action        (action),
    .handler_id    (handler_id),
    .argument      (argument),
    .delay         (delay),
    .repeat_count  (repeat_count),
    .cmd           (cmd),
    .stat          (stat),
    .strobe        (strobe),
    .kind          (kind),
    .fired_handler (fired_handler),
    .fired_argument(fired_argument),
    .repeats_left  (repeats_left),
    .last          (last)
  );

endmodule

// ===== tb/sv/delta_list_timer_queue_test.sv =====
// testbench for the delta list timer queue: scoreboard class, driver tasks, top
module delta_list_timer_queue_test;

  timeunit 1ns;
  timeprecision 1ps;

  // one result item of the block
  typedef struct {
    dltq_pkg::kind_t kind;
    logic [7:0]      handler;
    logic [31:0]     arg;
    logic [15:0]     reps;
    logic            last;
  } timeout_event_t;

  // predicts the timer table and checks the result stream
  class timer_table_board;
    logic [7:0]  tbl_handler[dltq_pkg::Capacity];
    logic [15:0] tbl_delta[dltq_pkg::Capacity];
    logic [31:0] tbl_arg[dltq_pkg::Capacity];
    logic [15:0] tbl_reps[dltq_pkg::Capacity];
    int          live;
    timeout_event_t pending_events[$];
    int errors;
    int results_seen;

    function new();
      live = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    // print one mismatch line and count it
    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    function void move_slot(int dst, int src);
      tbl_handler[dst] = tbl_handler[src];
      tbl_delta[dst] = tbl_delta[src];
      tbl_arg[dst] = tbl_arg[src];
      tbl_reps[dst] = tbl_reps[src];
    endfunction

    function void push_event(dltq_pkg::kind_t k, logic [7:0] h, logic [31:0] a,
                             logic [15:0] r, logic l);
      timeout_event_t e;
      e.kind = k;
      e.handler = h;
      e.arg = a;
      e.reps = r;
      e.last = l;
      pending_events.push_back(e);
    endfunction

    // note an accepted input item and queue its expected results
    function void note_item(dltq_pkg::action_t act, logic [7:0] h, logic [31:0] a,
                            logic [15:0] dly, logic [15:0] rep);
      int i;
      int fired;
      int pos;
      logic [15:0] t;
      logic [16:0] s;
      case (act)
        dltq_pkg::ACT_TICK: begin
          if (live == 0) return;
          for (i = 0; i < live; i++) begin
            if (tbl_delta[i] != 0) begin
              tbl_delta[i] = tbl_delta[i] - 16'd1;
              break;
            end
          end
          fired = 0;
          while (fired < live && tbl_delta[fired] == 0) fired++;
          for (i = 0; i < fired; i++)
            push_event(dltq_pkg::KIND_FIRED, tbl_handler[i], tbl_arg[i],
                       (tbl_reps[i] != 0) ? tbl_reps[i] - 16'd1 : 16'd0,
                       i == fired - 1);
          for (i = 0; i < live - fired; i++) move_slot(i, i + fired);
          live -= fired;
        end
        dltq_pkg::ACT_SCHEDULE: begin
          if (live >= dltq_pkg::Capacity) begin
            push_event(dltq_pkg::KIND_FULL, h, a, rep, 1'b1);
            return;
          end
          t = dly;
          pos = 0;
          while (pos < live && tbl_delta[pos] <= t) begin
            t -= tbl_delta[pos];
            pos++;
          end
          if (pos < live) tbl_delta[pos] = tbl_delta[pos] - t;
          for (i = live; i > pos; i--) move_slot(i, i - 1);
          tbl_handler[pos] = h;
          tbl_delta[pos] = t;
          tbl_arg[pos] = a;
          tbl_reps[pos] = rep;
          live++;
          push_event(dltq_pkg::KIND_SCHEDULED, h, a, rep, 1'b1);
        end
        dltq_pkg::ACT_CANCEL: begin
          for (i = 0; i < live; i++) if (tbl_handler[i] == h) break;
          if (i >= live) begin
            push_event(dltq_pkg::KIND_NOT_FOUND, h, 32'd0, 16'd0, 1'b1);
            return;
          end
          push_event(dltq_pkg::KIND_CANCELLED, h, tbl_arg[i], tbl_reps[i], 1'b1);
          if (i + 1 < live) begin
            s = {1'b0, tbl_delta[i + 1]} + {1'b0, tbl_delta[i]};
            tbl_delta[i + 1] = s[16] ? 16'hFFFF : s[15:0];
          end
          while (i + 1 < live) begin
            move_slot(i, i + 1);
            i++;
          end
          live--;
        end
        default: ;
      endcase
    endfunction

    // compare one result with the oldest expectation
    task check_result(logic [2:0] k, logic [7:0] h, logic [31:0] a,
                      logic [15:0] r, logic l);
      timeout_event_t e;
      results_seen++;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d handler=%0h", k, h));
        return;
      end
      e = pending_events.pop_front();
      if (k !== e.kind)
        report_mismatch($sformatf("kind %0d, want %0d", k, e.kind));
      if (h !== e.handler)
        report_mismatch($sformatf("handler %0h, want %0h", h, e.handler));
      if (a !== e.arg)
        report_mismatch($sformatf("argument %0h, want %0h", a, e.arg));
      if (r !== e.reps)
        report_mismatch($sformatf("repeats %0d, want %0d", r, e.reps));
      if (l !== e.last)
        report_mismatch($sformatf("last %0b, want %0b", l, e.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action = dltq_pkg::ACT_NONE;
  logic [7:0]  handler_id = '0;
  logic [31:0] argument = '0;
  logic [15:0] delay = '0;
  logic [15:0] repeat_count = '0;
  logic        strobe;
  logic [2:0]  kind;
  logic [7:0]  fired_handler;
  logic [31:0] fired_argument;
  logic [15:0] repeats_left;
  logic        last;

  timer_table_board board = new();
  int cycles = 0;
  int gaps_on = 1;
  int items_sent = 0;

  delta_list_timer_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .handler_id(handler_id), .argument(argument),
    .delay(delay), .repeat_count(repeat_count),
    .strobe(strobe), .kind(kind), .fired_handler(fired_handler),
    .fired_argument(fired_argument), .repeats_left(repeats_left), .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // results sampled at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && strobe)
      board.check_result(kind, fired_handler, fired_argument, repeats_left, last);
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // present one item and hold it until taken; a random gap sometimes follows
  task automatic send_item(dltq_pkg::action_t act, logic [7:0] h, logic [31:0] a,
                           logic [15:0] dly, logic [15:0] rep);
    int gap;
    action <= act;
    handler_id <= h;
    argument <= a;
    delay <= dly;
    repeat_count <= rep;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_item(act, h, a, dly, rep);
    items_sent++;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
  endtask

  // handler ids kept in a narrow pool so cancels hit often
  function automatic logic [7:0] pick_handler();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 7)) ^ ($urandom_range(0, 1) ? 8'hF8 : 8'h00);
  endfunction

  function automatic logic [15:0] pick_delay();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 6));
    endcase
  endfunction

  initial begin
    int i;
    int act_pick;
    int drain;
    dltq_pkg::action_t act;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, same-time entries, fill to full
    send_item(dltq_pkg::ACT_TICK, 8'h00, 32'h0, 16'h0, 16'h0);
    send_item(dltq_pkg::ACT_CANCEL, 8'hFF, 32'h0, 16'h0, 16'h0);
    send_item(dltq_pkg::ACT_NONE, 8'hAA, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
    send_item(dltq_pkg::ACT_SCHEDULE, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
    send_item(dltq_pkg::ACT_SCHEDULE, 8'h01, 32'h12345678, 16'd0, 16'd0);
    send_item(dltq_pkg::ACT_SCHEDULE, 8'h02, 32'h0, 16'd0, 16'd1);
    send_item(dltq_pkg::ACT_SCHEDULE, 8'h03, 32'hA5A5A5A5, 16'd2, 16'd3);
    send_item(dltq_pkg::ACT_TICK, 8'h00, 32'h0, 16'h0, 16'h0);
    send_item(dltq_pkg::ACT_TICK, 8'h00, 32'h0, 16'h0, 16'h0);
    send_item(dltq_pkg::ACT_TICK, 8'h00, 32'h0, 16'h0, 16'h0);
    send_item(dltq_pkg::ACT_CANCEL, 8'hFF, 32'h0, 16'h0, 16'h0);
    for (i = 0; i < 16; i++)
      send_item(dltq_pkg::ACT_SCHEDULE, i[7:0], $urandom, 16'd0, i[15:0]);
    send_item(dltq_pkg::ACT_TICK, 8'h00, 32'h0, 16'h0, 16'h0);

    // random: mostly schedules and ticks, cancels on a small handler pool
    for (i = 0; i < 310; i++) begin
      if (i == 270) gaps_on = 0;
      act_pick = $urandom_range(0, 19);
      if (act_pick < 8) act = dltq_pkg::ACT_SCHEDULE;
      else if (act_pick < 15) act = dltq_pkg::ACT_TICK;
      else if (act_pick < 19) act = dltq_pkg::ACT_CANCEL;
      else act = dltq_pkg::ACT_NONE;
      send_item(act, pick_handler(), $urandom, pick_delay(), 16'($urandom));
    end
    start <= 1'b0;

    // drain, then allow the block to settle
    drain = 0;
    while (board.pending_events.size() != 0 && drain < 10000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (board.pending_events.size() != 0)
      board.report_mismatch($sformatf("%0d results never arrived",
                                      board.pending_events.size()));
    $display("run covered %0d items and %0d results over %0d cycles",
             items_sent, board.results_seen, cycles);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== delta_list_timer_queue.f =====
rtl/dltq_pkg.sv
rtl/dltq_datapath.sv
rtl/dltq_ctrl.sv
rtl/delta_list_timer_queue.sv
tb/sv/delta_list_timer_queue_test.sv
